// ===== rtl/core/utf8_stream_decoder_defines.svh =====
// Assertion macros used by the top-level decoder file.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Antecedent holds: consequent holds in the same cycle.
`define U8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed");
// Antecedent holds: consequent holds in the next cycle.
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed");
`else
`define U8D_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/u8d_pkg.sv =====
package u8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned MIN_W   = 17;
    localparam int unsigned HALF_W  = 10;
    localparam int unsigned RES_MAX = 3;
    localparam int unsigned Q_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [0:0] CFG_STRICT = 1'b0;
    localparam logic [0:0] CFG_SKIP   = 1'b1;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_ILLEGAL    = 2'd1,
        ST_INCOMPLETE = 2'd2
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        t_status         st;
    } t_result;

    // All results caused by one input byte, oldest in slot 0.
    typedef struct packed {
        logic [1:0]               cnt;
        t_result [RES_MAX-1:0]    res;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/u8d_if.sv =====
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        run_end;

    modport source (output valid, code_point, status, run_end, input ready);
    modport sink   (input valid, code_point, status, run_end, output ready);
endinterface

// ===== rtl/core/utf8_stream_decoder.sv =====
// Channel  Dir  Handshake      Word contents
// i_in     in   valid/ready    data_byte[7:0], final_byte
// o_out    out  valid/ready    code_point[20:0], status[1:0], run_end
// cfg      in   i_cfg_we only  i_cfg_idx (0 strict_mode, 1 skip_invalid), i_cfg_data
//
// One input word is taken per cycle while the result queue has room; it is
// classified in the same cycle and up to three results are queued (a byte
// may give none). Results leave one per cycle while o_out.ready is high;
// sustained input rate is one word per cycle while each byte yields at most
// one result and the consumer is ready. The first result passes through the
// queue and is registered in the output stage before it is presented.
// Synchronous active-low reset restores strict mode, clears skip, and
// empties the decoder state, the queue and the output stage.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder import u8d_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data
);

    // The front decodes bytes and keeps the sequence and surrogate state.
    // Everything a byte produces is packed into one queue entry, so the
    // back end only has to walk through the entry's results in order.
    logic    push;
    logic    pop;
    t_entry  entry;
    t_entry  head;
    t_q_stat q_stat;

    u8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_entry    (entry)
    );

    // The queue decouples the byte side from the result side, so a stalled
    // consumer does not stop decoding until the queue fills.
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // The back end holds one entry and presents its results one per cycle while
    // o_out.ready is high, marking the last with run_end.
    u8d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // More results of the same byte must follow without a gap.
    `U8D_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_out.valid && !o_out.run_end, o_out.valid)
    // An incomplete report is always the last word of its byte and carries zero.
    `U8D_ASSERT_SAME(a_incomplete_last, i_clk, i_rst_n,
        o_out.valid && (o_out.status == ST_INCOMPLETE),
        o_out.run_end && (o_out.code_point == '0))
    // Faults reported as illegal never carry a code point.
    `U8D_ASSERT_SAME(a_illegal_zero, i_clk, i_rst_n,
        o_out.valid && (o_out.status == ST_ILLEGAL), o_out.code_point == '0)
    // The front never writes an entry into a full queue.
    `U8D_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, push, !q_stat.full)

endmodule

// ===== rtl/core/u8d_front.sv =====
module u8d_front import u8d_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8d_in_if.sink         i_in,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [0:0]     i_cfg_data,
    input  t_q_stat        i_q_stat,
    output logic           o_push,
    output t_entry         o_entry
);

    logic              r_strict;
    logic              r_skip;
    logic [CP_W-1:0]   r_acc;
    logic [1:0]        r_rem;
    logic [MIN_W-1:0]  r_min;
    logic [HALF_W-1:0] r_high;
    logic              r_pend;

    logic [CP_W-1:0]   n_acc;
    logic [1:0]        n_rem;
    logic [MIN_W-1:0]  n_min;
    logic [HALF_W-1:0] n_high;
    logic              n_pend;

    logic              accept;
    logic [7:0]        b;
    logic              is_cont;
    logic [CP_W-1:0]   acc_sh;
    logic              pre_fault;
    logic              do_lead;
    logic              seq_done;
    logic              lead_ascii;
    logic              lead_bad;
    logic              do_value;
    logic [CP_W-1:0]   val;
    logic [MIN_W-1:0]  vmin;
    logic              surr;
    logic              illegal;
    logic              bad;
    logic              is_hi;
    logic              is_lo;
    logic              joined;
    logic [CP_W-1:0]   pair_cp;
    t_status           fs;
    t_entry            ent;

    function automatic t_entry f_push(t_entry e, logic [CP_W-1:0] cp, t_status st);
        t_entry r;
        r = e;
        if (e.cnt != 2'd3) begin
            r.res[e.cnt].cp = cp;
            r.res[e.cnt].st = st;
            r.cnt           = e.cnt + 2'd1;
        end
        return r;
    endfunction

    assign accept      = i_in.valid && !i_q_stat.full;
    assign i_in.ready  = !i_q_stat.full;
    assign b           = i_in.data_byte;

    assign is_cont     = (b[7:6] == 2'b10);
    assign acc_sh      = {r_acc[CP_W-7:0], b[5:0]};
    assign pre_fault   = (r_rem != 2'd0) && !is_cont;
    assign do_lead     = (r_rem == 2'd0) || !is_cont;
    assign seq_done    = (r_rem == 2'd1) && is_cont;
    assign lead_ascii  = !b[7];
    assign lead_bad    = (b[7] && (b < 8'hc2)) || (b > 8'hf4);
    assign do_value    = seq_done || (do_lead && lead_ascii);
    assign val         = seq_done ? acc_sh : {13'd0, b};
    assign vmin        = seq_done ? r_min : '0;

    // Value checks; the surrogate range is 0xD800..0xDFFF.
    assign surr    = (val[20:11] == 10'h01b);
    assign is_hi   = (val[20:10] == 11'h036);
    assign is_lo   = (val[20:10] == 11'h037);
    assign illegal = (val >= 21'h00fdd0) &&
                     ((val > 21'h10ffff) || (val[15:1] == 15'h7fff) || (val < 21'h00fdf0));
    assign bad     = (r_strict && ((val < {4'd0, vmin}) || surr)) ||
                     (!r_skip && illegal);
    assign pair_cp = {1'b0, r_high, val[9:0]} + 21'h010000;
    assign fs      = r_skip ? ST_VALID : ST_ILLEGAL;

    always_comb begin
        ent    = '0;
        n_pend = r_pend;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_min  = r_min;
        n_high = r_high;
        joined = 1'b0;

        if ((r_rem != 2'd0) && is_cont) begin
            n_acc = acc_sh;
            n_rem = r_rem - 2'd1;
        end

        // A broken sequence reports first; the byte then starts over as a lead.
        if (pre_fault) begin
            n_rem = 2'd0;
            if (n_pend) begin
                n_pend = 1'b0;
                ent    = f_push(ent, '0, fs);
            end
            ent = f_push(ent, '0, fs);
        end

        if (do_lead && lead_bad) begin
            if (n_pend) begin
                n_pend = 1'b0;
                ent    = f_push(ent, '0, fs);
            end
            ent = f_push(ent, '0, fs);
        end else if (do_lead && !lead_ascii) begin
            if (b < 8'he0) begin
                n_acc = {16'd0, b[4:0]};
                n_rem = 2'd1;
                n_min = 17'h00080;
            end else if (b < 8'hf0) begin
                n_acc = {17'd0, b[3:0]};
                n_rem = 2'd2;
                n_min = 17'h00800;
            end else begin
                n_acc = {18'd0, b[2:0]};
                n_rem = 2'd3;
                n_min = 17'h10000;
            end
        end

        if (do_value) begin
            if (bad) begin
                if (n_pend) begin
                    n_pend = 1'b0;
                    ent    = f_push(ent, '0, fs);
                end
                ent = f_push(ent, '0, fs);
            end else begin
                if (n_pend) begin
                    n_pend = 1'b0;
                    if (is_lo) begin
                        ent    = f_push(ent, pair_cp, ST_VALID);
                        joined = 1'b1;
                    end else begin
                        ent = f_push(ent, '0, fs);
                    end
                end
                if (!joined) begin
                    if (!r_strict && is_hi) begin
                        n_high = val[HALF_W-1:0];
                        n_pend = 1'b1;
                    end else if (!r_strict && is_lo) begin
                        ent = f_push(ent, '0, fs);
                    end else begin
                        ent = f_push(ent, val, ST_VALID);
                    end
                end
            end
        end

        if (i_in.final_byte && ((n_rem != 2'd0) || n_pend)) begin
            ent    = f_push(ent, '0, ST_INCOMPLETE);
            n_rem  = 2'd0;
            n_pend = 1'b0;
            n_acc  = '0;
        end
    end

    assign o_push  = accept && (ent.cnt != 2'd0);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
            r_skip   <= 1'b0;
            r_acc    <= '0;
            r_rem    <= 2'd0;
            r_min    <= '0;
            r_high   <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STRICT: r_strict <= i_cfg_data[0];
                    CFG_SKIP:   r_skip   <= i_cfg_data[0];
                    default:    ;
                endcase
            end
            if (accept) begin
                r_acc  <= n_acc;
                r_rem  <= n_rem;
                r_min  <= n_min;
                r_high <= n_high;
                r_pend <= n_pend;
            end
        end
    end

endmodule

// ===== rtl/core/u8d_queue.sv =====
module u8d_queue import u8d_pkg::*; #(
    parameter int unsigned DEPTH = Q_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/u8d_back.sv =====
module u8d_back import u8d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    u8d_out_if.source o_out
);

    t_entry     r_ent;
    logic [1:0] r_idx;
    logic       r_full;
    logic       last;
    logic       load;

    assign last  = (r_idx == (r_ent.cnt - 2'd1));
    assign load  = !r_full || (o_out.ready && last);
    assign o_pop = load && !i_q_stat.empty;

    assign o_out.valid      = r_full;
    assign o_out.code_point = r_ent.res[r_idx].cp;
    assign o_out.status     = r_ent.res[r_idx].st;
    assign o_out.run_end    = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_full <= !i_q_stat.empty;
            r_idx  <= 2'd0;
        end else if (o_out.ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule
